// ----- design/tcs_pkg.sv -----
// shared types and constants of the text chunk splitter
`timescale 1ns / 1ps
package tcs_pkg;

	localparam logic [2:0] REG_MARKDOWN  = 3'd0;
	localparam logic [2:0] REG_SENTENCE  = 3'd1;
	localparam logic [2:0] REG_WIN_MAX   = 3'd2;
	localparam logic [2:0] REG_WIN_OVLP  = 3'd3;
	localparam logic [2:0] REG_MAX_TEXT  = 3'd4;

	localparam logic [1:0] ST_CHUNK   = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_BADWIN  = 2'd2;
	localparam logic [1:0] ST_TOOLONG = 2'd3;

	localparam logic [1:0] LM_PREFIX = 2'd0;
	localparam logic [1:0] LM_BODY   = 2'd1;
	localparam logic [1:0] LM_HEAD   = 2'd2;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_EXCL  = 8'h21;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_E3    = 8'hE3;
	localparam logic [7:0] CH_80    = 8'h80;
	localparam logic [7:0] CH_82    = 8'h82;
	localparam logic [7:0] CH_EF    = 8'hEF;
	localparam logic [7:0] CH_BC    = 8'hBC;
	localparam logic [7:0] CH_81    = 8'h81;
	localparam logic [7:0] CH_9F    = 8'h9F;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = 2;

	typedef struct packed {
		logic [31:0] idx;
		logic [31:0] off;
		logic [31:0] len;
		logic [31:0] hoff;
		logic [31:0] hlen;
		logic [1:0]  status;
		logic        last;
	} res_t;

	typedef struct packed {
		logic valid;
		logic room2;
	} qstat_t;

	function automatic logic is_ws(input logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR
			|| b == CH_FF || b == CH_VT;
	endfunction

endpackage

// ----- design/tcs_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
module tcs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/tcs_outq.sv -----
// result queue taking up to two results per cycle
`timescale 1ns / 1ps
module tcs_outq import tcs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push0,
	input  logic   push1,
	input  res_t   d0,
	input  res_t   d1,
	input  logic   pop,
	output res_t   head,
	output qstat_t stat
);

	res_t              ent_q [OQ_DEPTH];
	logic [OQ_AW-1:0]  wr_q;
	logic [OQ_AW-1:0]  rd_q;
	logic [OQ_AW:0]    cnt_q;
	logic [OQ_AW:0]    cnt_add;
	logic              pop_ok;

	assign pop_ok = pop && cnt_q != '0;
	assign cnt_add = push1 ? (OQ_AW+1)'(2) : (push0 ? (OQ_AW+1)'(1) : '0);
	assign head = ent_q[rd_q];
	assign stat = {cnt_q != '0, cnt_q <= (OQ_AW+1)'(OQ_DEPTH - 2)};

	always_ff @(posedge clk) begin
		if (push0) begin
			ent_q[wr_q] <= d0;
		end
		if (push1) begin
			ent_q[wr_q + OQ_AW'(1)] <= d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + cnt_add[OQ_AW-1:0];
			if (pop_ok) begin
				rd_q <= rd_q + OQ_AW'(1);
			end
			cnt_q <= cnt_q + cnt_add - (pop_ok ? (OQ_AW+1)'(1) : '0);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (OQ_AW+1)'(OQ_DEPTH))
		else $error("result queue overflow");
	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push1 |-> push0)
		else $error("second result without first");
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		push0 |-> stat.room2)
		else $error("push into full queue");

endmodule

// ----- design/text_chunk_splitter.sv -----
// top level of the text chunk splitter: byte parser, unit start ring and chunk windows
// results: the results of a byte enter the result queue at the edge that takes the byte, and
// appear on the output once they reach the head of that queue
// throughput: one byte per cycle; a byte yields at most two results, and the byte input
// stalls while the four-entry result queue has fewer than two free entries
// reset: registers return to their defaults, document state clears; ring contents stay
`timescale 1ns / 1ps
module text_chunk_splitter import tcs_pkg::*; #(
	parameter int MAX_UNITS   = 256,
	parameter int OFFSET_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  doc_byte,
	input  logic        end_of_document,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] chunk_index,
	output logic [31:0] chunk_offset,
	output logic [31:0] chunk_length,
	output logic [31:0] heading_offset,
	output logic [31:0] heading_length,
	output logic [1:0]  status,
	output logic        last_result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int OB = OFFSET_BITS;
	localparam int AW = $clog2(MAX_UNITS);
	localparam int CW = $clog2(MAX_UNITS + 1);
	localparam int KW = ((CW > 9) ? CW : 9) + 1;
	localparam int LW = ((OB + 2) > 33) ? (OB + 2) : 33;

	function automatic logic [31:0] lo32(input logic [OB-1:0] v);
		logic [OB+31:0] t;
		t = {32'd0, v};
		return t[31:0];
	endfunction

	logic        md_q, sbs_q;
	logic [8:0]  wmax_q, wov_q;
	logic [31:0] mtl_q;

	logic [OB-1:0] pos_q, endl_q, pend_q, lnse_q, hstart_q, hlen_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] first_q;
	logic          open_q, stop_q, cov_q;
	logic [15:0]   prev2_q;
	logic [1:0]    lmode_q, lsp_q;
	logic [2:0]    lh_q;
	logic [31:0]   ctr_q;
	logic          held_v_q;
	res_t          held_q;
	logic          byp_q;
	logic [OB-1:0] byp_d_q;

	logic [OB-1:0] pos_n, endl_n, pend_n, lnse_n, hstart_n, hlen_n;
	logic [CW-1:0] cnt_n;
	logic [AW-1:0] first_n;
	logic          open_n, stop_n, cov_n;
	logic [1:0]    lmode_n, lsp_n;
	logic [2:0]    lh_n;
	logic [31:0]   ctr_n;
	logic          held_v_n;
	res_t          held_n;

	logic          accept;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [OB-1:0] wdata, rdata;
	logic [OB-1:0] head;
	logic          push0, push1;
	res_t          r0, r1, qhead;
	qstat_t        qstat;
	logic          wok;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = !qstat.room2;
	assign cfg_ready = 1'b1;
	assign wok = wmax_q != 9'd0 && KW'(wmax_q) <= KW'(MAX_UNITS) && wov_q < wmax_q;

	always_comb begin
		logic          ws, ub_run, ub_close, head_sect, sect, close_en, emit_en, term;
		logic [OB-1:0] pos1, hb, ub_end, cl_end, emit_end, elen;
		logic [KW-1:0] cnt_p1, wsum, fsum, step;
		logic [LW-1:0] tot;
		logic [1:0]    np;
		res_t          rs [2];
		res_t          x;

		pos1 = pos_q + OB'(1);
		hb   = pos_q - OB'(lh_q);
		ws   = is_ws(doc_byte);
		ub_run = 1'b0; ub_close = 1'b0; head_sect = 1'b0; close_en = 1'b0;
		emit_en = 1'b0; term = 1'b0; sect = 1'b0;
		ub_end = '0; cl_end = '0; emit_end = '0; elen = '0; tot = '0;
		cnt_p1 = KW'(cnt_q) + KW'(1);
		step = KW'(wmax_q) - KW'(wov_q);
		wsum = KW'(first_q) + KW'(cnt_q);
		if (wsum >= KW'(MAX_UNITS)) begin
			wsum = wsum - KW'(MAX_UNITS);
		end
		fsum = KW'(first_q) + step;
		if (fsum >= KW'(MAX_UNITS)) begin
			fsum = fsum - KW'(MAX_UNITS);
		end
		np = '0;
		rs[0] = '0; rs[1] = '0; x = '0;

		pos_n = pos_q; endl_n = endl_q; pend_n = pend_q; lnse_n = lnse_q;
		hstart_n = hstart_q; hlen_n = hlen_q; cnt_n = cnt_q; first_n = first_q;
		open_n = open_q; stop_n = stop_q; cov_n = cov_q; lmode_n = lmode_q;
		lsp_n = lsp_q; lh_n = lh_q; ctr_n = ctr_q; held_v_n = held_v_q; held_n = held_q;
		we = 1'b0; waddr = wsum[AW-1:0]; wdata = pend_q;
		head = byp_q ? byp_d_q : rdata;

		if (!stop_q) begin
			if (!wok) begin
				held_v_n = 1'b0;
				x = '0; x.status = ST_BADWIN; x.last = 1'b1;
				rs[np[0]] = x; np = np + 2'd1;
				stop_n = 1'b1;
			end else begin
				if (!md_q) begin
					ub_run = 1'b1;
				end else begin
					case (lmode_q)
						LM_HEAD: begin
							if (doc_byte == CH_LF) begin
								hlen_n = pos_q - hstart_q
									- ((prev2_q[7:0] == CH_CR) ? OB'(1) : OB'(0));
								lmode_n = LM_PREFIX; lsp_n = '0; lh_n = '0;
							end
						end
						LM_PREFIX: begin
							if (lh_q == 3'd0 && doc_byte == CH_SPACE && lsp_q < 2'd3) begin
								lsp_n = lsp_q + 2'd1;
							end else if (doc_byte == CH_HASH && lh_q < 3'd6) begin
								lh_n = lh_q + 3'd1;
							end else if (lh_q != 3'd0 && ws) begin
								head_sect = 1'b1;
								hstart_n = hb;
								lsp_n = '0; lh_n = '0;
								if (doc_byte == CH_LF) begin
									hlen_n = OB'(lh_q);
									lmode_n = LM_PREFIX;
								end else begin
									hlen_n = '0;
									lmode_n = LM_HEAD;
								end
							end else begin
								if (lh_q != 3'd0) begin
									if (!open_n) begin
										open_n = 1'b1; pend_n = hb;
									end
									if (sbs_q) begin
										lnse_n = pos_q;
									end
								end
								lmode_n = LM_BODY; lsp_n = '0; lh_n = '0;
								ub_run = 1'b1;
							end
						end
						default: begin
							ub_run = 1'b1;
						end
					endcase
				end

				if (ub_run) begin
					if (!sbs_q) begin
						if (ws) begin
							if (open_n) begin
								ub_close = 1'b1; ub_end = pos_q;
							end
						end else if (!open_n) begin
							open_n = 1'b1; pend_n = pos_q;
						end
					end else if (!ws) begin
						if (!open_n) begin
							open_n = 1'b1; pend_n = pos_q;
						end
						lnse_n = pos1;
						term = doc_byte == CH_DOT || doc_byte == CH_EXCL
							|| doc_byte == CH_QUEST
							|| (doc_byte == CH_82 && prev2_q == {CH_E3, CH_80})
							|| ((doc_byte == CH_81 || doc_byte == CH_9F)
								&& prev2_q == {CH_EF, CH_BC});
						if (term) begin
							ub_close = 1'b1; ub_end = pos1;
						end
					end
					if (md_q && doc_byte == CH_LF) begin
						lmode_n = LM_PREFIX; lsp_n = '0; lh_n = '0;
					end
				end

				sect = head_sect || end_of_document;
				close_en = ub_close || (sect && open_n);
				cl_end = ub_close ? ub_end : (sbs_q ? lnse_n : (head_sect ? hb : pos1));
				if (close_en) begin
					we = 1'b1; wdata = pend_n;
					if (cnt_q == '0) begin
						head = pend_n;
					end
					endl_n = cl_end; open_n = 1'b0; cov_n = 1'b0;
					cnt_n = cnt_p1[CW-1:0];
					if (cnt_p1 >= KW'(wmax_q)) begin
						emit_en = 1'b1; emit_end = cl_end;
						first_n = fsum[AW-1:0];
						cnt_n = CW'(cnt_p1 - step);
						cov_n = 1'b1;
					end
				end
				if (sect) begin
					if (cnt_n != '0 && !cov_n) begin
						emit_en = 1'b1; emit_end = endl_n;
					end
					cnt_n = '0; first_n = '0; cov_n = 1'b0; open_n = 1'b0;
				end

				if (emit_en) begin
					elen = emit_end - head;
					tot = LW'(hlen_q) + LW'(1) + LW'(elen);
					if (hlen_q != '0 && tot > LW'(mtl_q)) begin
						held_v_n = 1'b0;
						x = '0; x.status = ST_TOOLONG; x.last = 1'b1;
						rs[np[0]] = x; np = np + 2'd1;
						stop_n = 1'b1;
					end else begin
						if (held_v_q) begin
							rs[np[0]] = held_q; np = np + 2'd1;
						end
						held_v_n = 1'b1;
						held_n.idx = ctr_q;
						held_n.off = lo32(head);
						held_n.len = lo32(elen);
						held_n.hlen = lo32(hlen_q);
						held_n.hoff = (hlen_q != '0) ? lo32(hstart_q) : 32'd0;
						held_n.status = ST_CHUNK;
						held_n.last = 1'b0;
						ctr_n = ctr_q + 32'd1;
					end
				end

				if (end_of_document && !stop_n) begin
					if (held_v_n) begin
						x = held_n; x.last = 1'b1;
					end else begin
						x = '0; x.status = ST_EMPTY; x.last = 1'b1;
					end
					rs[np[0]] = x; np = np + 2'd1;
					held_v_n = 1'b0;
				end
			end
		end

		if (end_of_document) begin
			pos_n = '0; endl_n = '0; cnt_n = '0; first_n = '0; pend_n = '0;
			lnse_n = '0; open_n = 1'b0; lmode_n = LM_PREFIX; lsp_n = '0; lh_n = '0;
			hstart_n = '0; hlen_n = '0; ctr_n = '0; stop_n = 1'b0; cov_n = 1'b0;
			held_v_n = 1'b0; held_n = '0;
		end else begin
			pos_n = pos1;
		end

		we    = we && accept;
		push0 = accept && np != 2'd0;
		push1 = accept && np == 2'd2;
		r0 = rs[0];
		r1 = rs[1];
		raddr = accept ? first_n : first_q;
	end

	tcs_ram #(
		.WIDTH (OB),
		.DEPTH (MAX_UNITS)
	) u_ring (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	tcs_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push0  (push0),
		.push1  (push1),
		.d0     (r0),
		.d1     (r1),
		.pop    (!out_stall),
		.head   (qhead),
		.stat   (qstat)
	);

	assign out_valid      = qstat.valid;
	assign chunk_index    = qhead.idx;
	assign chunk_offset   = qhead.off;
	assign chunk_length   = qhead.len;
	assign heading_offset = qhead.hoff;
	assign heading_length = qhead.hlen;
	assign status         = qhead.status;
	assign last_result    = qhead.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			md_q <= 1'b0;
			sbs_q <= 1'b0;
			wmax_q <= 9'd128;
			wov_q <= 9'd0;
			mtl_q <= 32'd262143;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MARKDOWN: md_q <= cfg_data[0];
				REG_SENTENCE: sbs_q <= cfg_data[0];
				REG_WIN_MAX:  wmax_q <= cfg_data[8:0];
				REG_WIN_OVLP: wov_q <= cfg_data[8:0];
				REG_MAX_TEXT: mtl_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; endl_q <= '0; pend_q <= '0; lnse_q <= '0;
			hstart_q <= '0; hlen_q <= '0; cnt_q <= '0; first_q <= '0;
			open_q <= 1'b0; stop_q <= 1'b0; cov_q <= 1'b0; prev2_q <= '0;
			lmode_q <= LM_PREFIX; lsp_q <= '0; lh_q <= '0; ctr_q <= '0;
			held_v_q <= 1'b0; held_q <= '0;
			byp_q <= 1'b0; byp_d_q <= '0;
		end else begin
			byp_q <= we && waddr == raddr;
			byp_d_q <= wdata;
			if (accept) begin
				pos_q <= pos_n; endl_q <= endl_n; pend_q <= pend_n; lnse_q <= lnse_n;
				hstart_q <= hstart_n; hlen_q <= hlen_n; cnt_q <= cnt_n; first_q <= first_n;
				open_q <= open_n; stop_q <= stop_n; cov_q <= cov_n;
				prev2_q <= end_of_document ? 16'd0 : {prev2_q[7:0], doc_byte};
				lmode_q <= lmode_n; lsp_q <= lsp_n; lh_q <= lh_n; ctr_q <= ctr_n;
				held_v_q <= held_v_n; held_q <= held_n;
			end
		end
	end

	a_stop_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		accept && stop_q |-> !push0)
		else $error("result after document error");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		KW'(cnt_q) < KW'(MAX_UNITS))
		else $error("unit count out of range");
	a_first_bound: assert property (@(posedge clk) disable iff (!arst_n)
		KW'(first_q) < KW'(MAX_UNITS))
		else $error("window start out of range");
	a_eod_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_document |=> pos_q == '0 && cnt_q == '0 && !held_v_q)
		else $error("document state not cleared");

endmodule
